FILE: sv/nmha_pkg.sv
package nmha_pkg;

  // Map entry codes
  localparam logic [3:0] FREE_MARK = 4'h0;
  localparam logic [3:0] CONT_MARK = 4'hF;

  // Request modes
  localparam logic [2:0] MODE_ALLOC    = 3'd0;
  localparam logic [2:0] MODE_FREE     = 3'd1;
  localparam logic [2:0] MODE_SIZE     = 3'd2;
  localparam logic [2:0] MODE_OWNER    = 3'd3;
  localparam logic [2:0] MODE_FREE_ALL = 3'd4;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOSPACE  = 3'd1;
  localparam logic [2:0] ST_OUTSIDE  = 3'd2;
  localparam logic [2:0] ST_NOTOWNER = 3'd3;
  localparam logic [2:0] ST_FREE     = 3'd4;

  localparam logic [15:0] BASE_RESET = 16'd256;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_LOAD,
    OP_DECODE,
    OP_WAIT,
    OP_CHK,
    OP_BACK,
    OP_FWD,
    OP_ALC,
    OP_ALW,
    OP_FALL,
    OP_PUSH
  } dp_op_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       alloc_ok;
    logic       pid_ok;
    logic       in_area;
    logic       byte_free;
    logic       found;
    logic       fwd_end;
    logic       alc_found;
    logic       alc_fail;
    logic       alw_last;
    logic       fall_end;
    logic       clr_last;
  } dp_stat_t;

endpackage

FILE: sv/nmha_req_if.sv
interface nmha_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [15:0] address;
  logic [9:0]  alloc_size;
  logic [3:0]  process_id;

  modport source (output valid, mode, address, alloc_size, process_id, input ready);
  modport sink (input valid, mode, address, alloc_size, process_id, output ready);
endinterface

FILE: sv/nmha_rsp_if.sv
interface nmha_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_address;
  logic [9:0]  chunk_length;
  logic [3:0]  chunk_owner;
  logic [2:0]  status;

  modport source (output valid, result_address, chunk_length, chunk_owner, status,
                  input ready);
  modport sink (input valid, result_address, chunk_length, chunk_owner, status,
                output ready);
endinterface

FILE: sv/nmha_datapath.sv
module nmha_datapath #(
  parameter int USE_SIZE = 512
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  input  logic [2:0]        in_mode,
  input  logic [15:0]       in_address,
  input  logic [9:0]        in_size,
  input  logic [3:0]        in_pid,
  input  nmha_pkg::dp_op_t  op,
  output nmha_pkg::dp_stat_t stat,
  output logic [15:0]       out_address,
  output logic [9:0]        out_length,
  output logic [3:0]        out_owner,
  output logic [2:0]        out_status
);

  localparam int AW = (USE_SIZE > 1) ? $clog2(USE_SIZE) : 1;
  localparam int LW = $clog2(USE_SIZE + 1);
  localparam logic [LW-1:0] SIZE_L = LW'(USE_SIZE);
  localparam logic [LW-1:0] LAST_L = LW'(USE_SIZE - 1);

  logic [3:0]    mem [USE_SIZE];
  logic [3:0]    rdata;
  logic [15:0]   base;
  logic [2:0]    mode;
  logic [15:0]   addr;
  logic [9:0]    size;
  logic [3:0]    pid;
  logic [LW-1:0] lim;
  logic [AW-1:0] off;
  logic [LW-1:0] ptr;
  logic [AW-1:0] dptr;
  logic          dv;
  logic [LW-1:0] run;
  logic [AW-1:0] s;
  logic          fwd_none;
  logic          flag;
  logic [9:0]    cnt;
  logic [15:0]   r_addr;
  logic [9:0]    r_len;
  logic [3:0]    r_own;
  logic [2:0]    r_st;

  logic [16:0]   room;
  logic [LW-1:0] lim_calc;
  logic [15:0]   diff;
  logic          in_area, pid_ok, alloc_ok;
  logic          at_last, is_cont, chk_here, back_hit, found;
  logic [AW-1:0] s_cur;
  logic          fwd_end;
  logic [LW-1:0] e_val;
  logic [LW-1:0] run_n;
  logic          alc_found, alc_fail, fall_hit, fall_cont, fall_end;
  logic [15:0]   start_alc;
  logic          we;
  logic [AW-1:0] wa;
  logic [3:0]    wd;

  assign room     = 17'h10000 - {1'b0, base};
  assign lim_calc = (room < 17'(USE_SIZE)) ? LW'(room) : SIZE_L;
  assign diff     = addr - base;
  assign in_area  = (addr >= base) && (diff < 16'(lim));
  assign pid_ok   = (pid != nmha_pkg::FREE_MARK) && (pid != nmha_pkg::CONT_MARK);
  assign alloc_ok = (size != 10'd0) && pid_ok && (16'(size) <= 16'(lim));

  assign at_last  = (LW'(dptr) == (lim - LW'(1)));
  assign is_cont  = (rdata == nmha_pkg::CONT_MARK);
  assign chk_here = !is_cont || (off == '0);
  assign back_hit = dv && (!is_cont || (dptr == '0));
  assign found    = ((op == nmha_pkg::OP_CHK) && (rdata != nmha_pkg::FREE_MARK) && chk_here) ||
                    ((op == nmha_pkg::OP_BACK) && back_hit);
  assign s_cur    = (op == nmha_pkg::OP_CHK) ? off : dptr;

  assign fwd_end  = (op == nmha_pkg::OP_FWD) && (fwd_none || (dv && (!is_cont || at_last)));
  assign e_val    = fwd_none ? (LW'(s) + LW'(1)) : (!is_cont ? LW'(dptr) : lim);

  assign run_n     = (rdata == nmha_pkg::FREE_MARK) ? (run + LW'(1)) : '0;
  assign alc_found = (op == nmha_pkg::OP_ALC) && dv && (16'(run_n) == 16'(size));
  assign alc_fail  = (op == nmha_pkg::OP_ALC) && dv && !alc_found && at_last;
  assign start_alc = 16'(dptr) + 16'd1 - 16'(size);

  assign fall_hit  = (rdata == pid);
  assign fall_cont = flag && is_cont;
  assign fall_end  = (op == nmha_pkg::OP_FALL) && dv && at_last;

  always_comb begin
    stat.mode      = mode;
    stat.alloc_ok  = alloc_ok;
    stat.pid_ok    = pid_ok;
    stat.in_area   = in_area;
    stat.byte_free = (rdata == nmha_pkg::FREE_MARK);
    stat.found     = found;
    stat.fwd_end   = fwd_end;
    stat.alc_found = alc_found;
    stat.alc_fail  = alc_fail;
    stat.alw_last  = (cnt == 10'd0);
    stat.fall_end  = fall_end;
    stat.clr_last  = (ptr == LAST_L);
  end

  // Map write port
  always_comb begin
    we = 1'b0;
    wa = ptr[AW-1:0];
    wd = nmha_pkg::FREE_MARK;
    case (op)
      nmha_pkg::OP_CLEAR: we = 1'b1;
      nmha_pkg::OP_CHK, nmha_pkg::OP_BACK: begin
        wa = s_cur;
        we = found && (mode == nmha_pkg::MODE_FREE);
      end
      nmha_pkg::OP_FWD: begin
        wa = dptr;
        we = (mode == nmha_pkg::MODE_FREE) && dv && !fwd_none && is_cont;
      end
      nmha_pkg::OP_ALW: begin
        we = 1'b1;
        wd = (ptr[AW-1:0] == s) ? pid : nmha_pkg::CONT_MARK;
      end
      nmha_pkg::OP_FALL: begin
        wa = dptr;
        we = dv && (fall_hit || fall_cont);
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rdata <= mem[ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      base <= nmha_pkg::BASE_RESET;
      dv   <= 1'b0;
    end else begin
      if (cfg_wr_en) base <= cfg_wr_data;
      dptr <= ptr[AW-1:0];
      dv   <= 1'b1;
      case (op)
        nmha_pkg::OP_CLEAR: ptr <= ptr + LW'(1);
        nmha_pkg::OP_LOAD: begin
          mode <= in_mode;
          addr <= in_address;
          size <= in_size;
          pid  <= in_pid;
          lim  <= lim_calc;
        end
        nmha_pkg::OP_DECODE: begin
          off    <= diff[AW-1:0];
          r_addr <= '0;
          r_len  <= '0;
          r_own  <= '0;
          run    <= '0;
          flag   <= 1'b0;
          dv     <= 1'b0;
          ptr    <= '0;
          case (mode) inside
            nmha_pkg::MODE_ALLOC: r_st <= nmha_pkg::ST_NOSPACE;
            nmha_pkg::MODE_FREE, nmha_pkg::MODE_SIZE, nmha_pkg::MODE_OWNER: begin
              r_st <= in_area ? nmha_pkg::ST_OK : nmha_pkg::ST_OUTSIDE;
              ptr  <= LW'(diff[AW-1:0]);
            end
            default: r_st <= nmha_pkg::ST_OK;
          endcase
        end
        nmha_pkg::OP_CHK, nmha_pkg::OP_BACK: begin
          if (op == nmha_pkg::OP_CHK) begin
            if (rdata == nmha_pkg::FREE_MARK) begin
              r_st <= nmha_pkg::ST_FREE;
            end else if (!chk_here) begin
              ptr <= LW'(off) - LW'(1);
              dv  <= 1'b0;
            end
          end else if (!back_hit && (ptr != '0)) begin
            ptr <= ptr - LW'(1);
          end
          if (found) begin
            s        <= s_cur;
            ptr      <= LW'(s_cur) + LW'(1);
            dv       <= 1'b0;
            fwd_none <= ((LW + 1)'(s_cur) + (LW + 1)'(1)) >= (LW + 1)'(lim);
            if (mode == nmha_pkg::MODE_OWNER) r_own <= rdata;
            if (mode == nmha_pkg::MODE_FREE)
              r_st <= (rdata != pid) ? nmha_pkg::ST_NOTOWNER : nmha_pkg::ST_OK;
          end
        end
        nmha_pkg::OP_FWD: begin
          if (ptr < lim) ptr <= ptr + LW'(1);
          if (fwd_end && (mode == nmha_pkg::MODE_SIZE)) r_len <= 10'(e_val - LW'(s));
        end
        nmha_pkg::OP_ALC: begin
          if (ptr < lim) ptr <= ptr + LW'(1);
          if (dv) run <= run_n;
          if (alc_found) begin
            s   <= start_alc[AW-1:0];
            ptr <= LW'(start_alc);
            cnt <= size - 10'd1;
          end
        end
        nmha_pkg::OP_ALW: begin
          ptr <= ptr + LW'(1);
          cnt <= cnt - 10'd1;
          if (cnt == 10'd0) begin
            r_addr <= base + 16'(s);
            r_st   <= nmha_pkg::ST_OK;
          end
        end
        nmha_pkg::OP_FALL: begin
          if (ptr < lim) ptr <= ptr + LW'(1);
          if (dv) flag <= fall_hit || fall_cont;
        end
        nmha_pkg::OP_PUSH: begin
          out_address <= r_addr;
          out_length  <= r_len;
          out_owner   <= r_own;
          out_status  <= r_st;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/nmha_ctrl.sv
module nmha_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  nmha_pkg::dp_stat_t stat,
  output nmha_pkg::dp_op_t   op
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_RD, S_CHK, S_BACK, S_FWD, S_ALC, S_ALW, S_FALL, S_FIN
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    op         = nmha_pkg::OP_IDLE;
    unique case (state)
      S_CLEAR: begin
        op = nmha_pkg::OP_CLEAR;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op         = nmha_pkg::OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        op = nmha_pkg::OP_DECODE;
        unique case (stat.mode) inside
          nmha_pkg::MODE_ALLOC: state_next = stat.alloc_ok ? S_ALC : S_FIN;
          nmha_pkg::MODE_FREE, nmha_pkg::MODE_SIZE, nmha_pkg::MODE_OWNER:
            state_next = stat.in_area ? S_RD : S_FIN;
          nmha_pkg::MODE_FREE_ALL: state_next = stat.pid_ok ? S_FALL : S_FIN;
          default: state_next = S_FIN;
        endcase
      end
      S_RD: begin
        op         = nmha_pkg::OP_WAIT;
        state_next = S_CHK;
      end
      S_CHK: begin
        op = nmha_pkg::OP_CHK;
        if (stat.byte_free) state_next = S_FIN;
        else if (stat.found) state_next = (stat.mode == nmha_pkg::MODE_OWNER) ? S_FIN : S_FWD;
        else state_next = S_BACK;
      end
      S_BACK: begin
        op = nmha_pkg::OP_BACK;
        if (stat.found) state_next = (stat.mode == nmha_pkg::MODE_OWNER) ? S_FIN : S_FWD;
      end
      S_FWD: begin
        op = nmha_pkg::OP_FWD;
        if (stat.fwd_end) state_next = S_FIN;
      end
      S_ALC: begin
        op = nmha_pkg::OP_ALC;
        if (stat.alc_found) state_next = S_ALW;
        else if (stat.alc_fail) state_next = S_FIN;
      end
      S_ALW: begin
        op = nmha_pkg::OP_ALW;
        if (stat.alw_last) state_next = S_FIN;
      end
      S_FALL: begin
        op = nmha_pkg::OP_FALL;
        if (stat.fall_end) state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          op         = nmha_pkg::OP_PUSH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (op == nmha_pkg::OP_PUSH) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (op == nmha_pkg::OP_PUSH) |=> out_valid)
    else $error("result not presented after push");

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DECODE))
    else $error("accepted request not decoded");

  a_alloc_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_ALC && stat.alc_found) |=> (state == S_ALW))
    else $error("found run not written");

  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_valid && !out_ready) |=> (state == S_FIN))
    else $error("finished result overwrote a pending one");

endmodule

FILE: sv/nibble_map_heap_allocator.sv
// Heap allocation map, one 4-bit entry per managed byte (0 free, 1..14 chunk start of that
// process, 15 continuation). Each request gives exactly one response. After reset the map is
// cleared by a sweep over all USE_SIZE entries during which no request is taken; configuration
// writes are to be taken only while idle, which the user must ensure: the block does not
// enforce it. Work is done on one map memory with one read and one write port, one entry per
// cycle: allocate scans up to the end of the first fitting run (at most the area length), then
// writes size entries; free-all walks the whole area; free and size query take a backward walk
// to the chunk start plus a forward walk over the chunk; owner query takes the backward walk
// only; fast rejects skip the walks. Area length is the smaller of USE_SIZE and 65536 - use_base.
module nibble_map_heap_allocator #(
  parameter int USE_SIZE = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  nmha_req_if.sink    req,
  nmha_rsp_if.source  rsp
);

  nmha_pkg::dp_op_t   op;
  nmha_pkg::dp_stat_t stat;
  logic               in_ready;
  logic               out_valid;

  // Hand the request handshake to the controller; the datapath latches the payload on load.
  assign req.ready = in_ready;
  assign rsp.valid = out_valid;

  nmha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .op        (op)
  );

  // Map memory, request registers, scan pointers and the response register.
  nmha_datapath #(
    .USE_SIZE (USE_SIZE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_mode     (req.mode),
    .in_address  (req.address),
    .in_size     (req.alloc_size),
    .in_pid      (req.process_id),
    .op          (op),
    .stat        (stat),
    .out_address (rsp.result_address),
    .out_length  (rsp.chunk_length),
    .out_owner   (rsp.chunk_owner),
    .out_status  (rsp.status)
  );

endmodule
